/* rtl/undirected_adjacency_bit_matrix_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the undirected adjacency bit matrix
// Concurrent checks on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef UNDIRECTED_ADJACENCY_BIT_MATRIX_DEFINES_SVH
`define UNDIRECTED_ADJACENCY_BIT_MATRIX_DEFINES_SVH

// same-cycle implication
`define UABM_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define UABM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/uabm_pkg.sv */
// ----------------------------------------------------------------------------
// uabm_pkg
// Command codes and beat types of the undirected adjacency bit matrix.
// ----------------------------------------------------------------------------
package uabm_pkg;

	localparam int ID_W = 6;

	localparam logic [2:0] CMD_ADD_EDGE   = 3'd0;
	localparam logic [2:0] CMD_REM_EDGE   = 3'd1;
	localparam logic [2:0] CMD_REM_NODE   = 3'd2;
	localparam logic [2:0] CMD_HAS_EDGE   = 3'd3;
	localparam logic [2:0] CMD_HAS_NODE   = 3'd4;
	localparam logic [2:0] CMD_LIST       = 3'd5;
	localparam logic [2:0] CMD_LIST_ABOVE = 3'd6;
	localparam logic [2:0] CMD_READ_CLEAR = 3'd7;

	typedef struct packed {
		logic [2:0]      cmd;
		logic [ID_W-1:0] node_a;
		logic [ID_W-1:0] node_b;
	} req_beat_t;

	typedef struct packed {
		logic            error;
		logic            answer;
		logic [ID_W-1:0] neighbour;
		logic            neighbour_valid;
		logic            last;
		logic            modified;
	} rsp_beat_t;

endpackage

/* rtl/uabm_stream_if.sv */
// ----------------------------------------------------------------------------
// uabm_stream_if
// Valid/ready channel carrying one beat of payload type T.
// ----------------------------------------------------------------------------
interface uabm_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/undirected_adjacency_bit_matrix.sv */
// Edge commands read and check row A and, when they change a link, write row A, then
// read and write row B; lookups and read-clear read row A only; node removal on a linked
// node also sweeps every row; lists scan up to W bit positions, one per cycle while no
// listed beat waits for the output slot. One command at a time: the next command is taken
// the cycle after the last beat of the current one is loaded. One-read one-write row memory.
// Reset clears the row valid bits and the modified flag at once; no clearing pass.
// ----------------------------------------------------------------------------
// undirected_adjacency_bit_matrix
// Symmetric link matrix in a row memory, served by a small command sequencer.
// ----------------------------------------------------------------------------
`include "undirected_adjacency_bit_matrix_defines.svh"

module undirected_adjacency_bit_matrix
	import uabm_pkg::*;
#(
	parameter int MAX_NODES = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	uabm_stream_if.sink   req,
	uabm_stream_if.source rsp
);

	localparam int W  = (MAX_NODES < 64) ? MAX_NODES : 64;
	localparam int IW = $clog2(W);
	localparam int CW = $clog2(W + 1);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_CHK   = 3'd2;
	localparam logic [2:0] S_RD_B  = 3'd3;
	localparam logic [2:0] S_WR_B  = 3'd4;
	localparam logic [2:0] S_SWEEP = 3'd5;
	localparam logic [2:0] S_EMIT  = 3'd6;
	localparam logic [2:0] S_LIST  = 3'd7;

	logic [2:0]      state_q;
	logic            flag_q;
	logic [W-1:0]    vld_q;
	logic            rd_vld_q;
	logic            out_vld_q;
	logic            pend_s1;
	logic [CW-1:0]   sw_cnt_q;

	logic [2:0]      cmd_q;
	logic [ID_W-1:0] a_q;
	logic [ID_W-1:0] b_q;
	logic            ans_q;
	logic            err_q;
	logic [W-1:0]    list_q;
	logic [ID_W-1:0] idx_q;
	logic [IW-1:0]   wr_idx_s1;
	logic [W-1:0]    rd_data_q;
	logic [W-1:0]    mem_q [W];
	rsp_beat_t       out_q;

	logic [W-1:0]    row_rd;
	logic            a_ok;
	logic            b_ok;
	logic            ok;
	logic            same;
	logic [IW-1:0]   a_idx;
	logic [IW-1:0]   b_idx;
	logic [W-1:0]    abit;
	logic [W-1:0]    bbit;
	logic [W-1:0]    above;
	logic            hit;
	logic            slot_free;
	logic            sw_rd;
	logic            rd_en;
	logic [IW-1:0]   rd_addr;
	logic            wr_en;
	logic [IW-1:0]   wr_addr;
	logic [W-1:0]    wr_data;
	logic            load;
	rsp_beat_t       ld;

	assign row_rd    = rd_vld_q ? rd_data_q : '0;
	assign a_ok      = {1'b0, a_q} < 7'(W);
	assign b_ok      = {1'b0, b_q} < 7'(W);
	assign ok        = a_ok && b_ok;
	assign same      = (a_q == b_q);
	assign a_idx     = a_q[IW-1:0];
	assign b_idx     = b_q[IW-1:0];
	assign abit      = {{(W-1){1'b0}}, 1'b1} << a_idx;
	assign bbit      = {{(W-1){1'b0}}, 1'b1} << b_idx;
	assign hit       = ok && row_rd[b_idx];
	assign slot_free = !out_vld_q || rsp.ready;
	assign sw_rd     = (sw_cnt_q < CW'(W));

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_vld_q;
	assign rsp.data  = out_q;

	always_comb begin
		for (int j = 0; j < W; j++) begin
			above[j] = (7'(j) > {1'b0, a_q});
		end
	end

	always_comb begin
		rd_en              = 1'b0;
		rd_addr            = a_idx;
		wr_en              = 1'b0;
		wr_addr            = a_idx;
		wr_data            = row_rd;
		load               = 1'b0;
		ld.error           = 1'b0;
		ld.answer          = 1'b0;
		ld.neighbour       = '0;
		ld.neighbour_valid = 1'b0;
		ld.last            = 1'b1;
		ld.modified        = flag_q;
		unique case (state_q)
			S_READ: begin
				rd_en = 1'b1;
			end
			S_CHK: begin
				if (cmd_q == CMD_ADD_EDGE && !same && ok && !row_rd[b_idx]) begin
					wr_en   = 1'b1;
					wr_data = row_rd | bbit;
				end else if (cmd_q == CMD_REM_EDGE && !same && hit) begin
					wr_en   = 1'b1;
					wr_data = row_rd & ~bbit;
				end
			end
			S_RD_B: begin
				rd_en   = 1'b1;
				rd_addr = b_idx;
			end
			S_WR_B: begin
				wr_en   = 1'b1;
				wr_addr = b_idx;
				wr_data = (cmd_q == CMD_ADD_EDGE) ? (row_rd | abit) : (row_rd & ~abit);
			end
			S_SWEEP: begin
				rd_en   = sw_rd;
				rd_addr = sw_cnt_q[IW-1:0];
				wr_en   = pend_s1;
				wr_addr = wr_idx_s1;
				wr_data = (wr_idx_s1 == a_idx) ? '0 : (row_rd & ~abit);
			end
			S_EMIT: begin
				load      = slot_free;
				ld.error  = err_q;
				ld.answer = ans_q;
			end
			S_LIST: begin
				if (list_q[0]) begin
					load               = slot_free;
					ld.neighbour       = idx_q;
					ld.neighbour_valid = 1'b1;
					ld.last            = ((list_q >> 1) == '0);
				end else if (list_q == '0) begin
					load = slot_free;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			flag_q    <= 1'b0;
			vld_q     <= '0;
			rd_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
			pend_s1   <= 1'b0;
			sw_cnt_q  <= '0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
			if (load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHK;
				end
				S_CHK: begin
					unique case (cmd_q) inside
						CMD_ADD_EDGE, CMD_REM_EDGE: begin
							if (wr_en) begin
								flag_q  <= 1'b1;
								state_q <= S_RD_B;
							end else begin
								state_q <= S_EMIT;
							end
						end
						CMD_REM_NODE: begin
							if (a_ok && row_rd != '0) begin
								flag_q   <= 1'b1;
								sw_cnt_q <= '0;
								pend_s1  <= 1'b0;
								state_q  <= S_SWEEP;
							end else begin
								state_q <= S_EMIT;
							end
						end
						CMD_HAS_EDGE, CMD_HAS_NODE: begin
							state_q <= S_EMIT;
						end
						CMD_LIST, CMD_LIST_ABOVE: begin
							state_q <= S_LIST;
						end
						CMD_READ_CLEAR: begin
							flag_q  <= 1'b0;
							state_q <= S_EMIT;
						end
						default: begin
							state_q <= S_EMIT;
						end
					endcase
				end
				S_RD_B: begin
					state_q <= S_WR_B;
				end
				S_WR_B: begin
					state_q <= S_EMIT;
				end
				S_SWEEP: begin
					pend_s1 <= sw_rd;
					if (sw_rd) begin
						sw_cnt_q <= sw_cnt_q + CW'(1);
					end
					if (!sw_rd && !pend_s1) begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				S_LIST: begin
					if (load && ld.last) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			cmd_q <= req.data.cmd;
			a_q   <= req.data.node_a;
			b_q   <= req.data.node_b;
		end
		if (state_q == S_CHK) begin
			err_q  <= same && (cmd_q == CMD_ADD_EDGE || cmd_q == CMD_REM_EDGE);
			idx_q  <= '0;
			list_q <= a_ok ? (row_rd & ((cmd_q == CMD_LIST_ABOVE) ? above : '1)) : '0;
			case (cmd_q) inside
				CMD_ADD_EDGE:             ans_q <= !same && ok && !row_rd[b_idx];
				CMD_REM_EDGE:             ans_q <= !same && hit;
				CMD_HAS_EDGE:             ans_q <= hit;
				CMD_REM_NODE, CMD_HAS_NODE: ans_q <= a_ok && (row_rd != '0);
				CMD_READ_CLEAR:           ans_q <= flag_q;
				default:                  ans_q <= 1'b0;
			endcase
		end
		if (state_q == S_LIST && (list_q[0] ? load : (list_q != '0))) begin
			list_q <= list_q >> 1;
			idx_q  <= idx_q + ID_W'(1);
		end
		if (state_q == S_SWEEP) begin
			wr_idx_s1 <= rd_addr;
		end
		if (load) begin
			out_q <= ld;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	`UABM_ASSERT_IMPL(a_sweep_no_collide, state_q == S_SWEEP && pend_s1 && sw_rd, wr_idx_s1 != rd_addr, "sweep write and read hit the same row")
	`UABM_ASSERT_IMPL(a_self_edge_no_write, state_q == S_CHK && same && (cmd_q == CMD_ADD_EDGE || cmd_q == CMD_REM_EDGE), !wr_en, "self edge wrote the matrix")
	`UABM_ASSERT_NEXT(a_flag_clear_cmd, flag_q && !(state_q == S_CHK && cmd_q == CMD_READ_CLEAR), flag_q, "modified flag dropped without read-clear")
	`UABM_ASSERT_IMPL(a_load_slot_free, load, slot_free, "result beat overwrote a pending beat")

endmodule

/* dv/tb_undirected_adjacency_bit_matrix.sv */
// ----------------------------------------------------------------------------
// tb_undirected_adjacency_bit_matrix
// Drives edge, node, lookup, list and read-clear commands into the matrix.
// Predicts every response beat from a private copy of the link rows and the
// modified flag, then checks each beat field by field in order. Both sides
// idle at random.
// ----------------------------------------------------------------------------
module tb_undirected_adjacency_bit_matrix
	import uabm_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int NODE_COUNT     = 64;
	localparam int RANDOM_ITEMS   = 220;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 150;

	typedef struct {
		req_beat_t beat;
		bit        drain;
	} cmd_item_t;

	logic clk;
	logic arst_n;

	uabm_stream_if #(.T(req_beat_t)) req_if ();
	uabm_stream_if #(.T(rsp_beat_t)) rsp_if ();

	undirected_adjacency_bit_matrix dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	logic [NODE_COUNT-1:0] graph_links [NODE_COUNT];
	bit                    dirty_flag;
	rsp_beat_t             due_beats [$];
	cmd_item_t             cmd_queue [$];

	int  mismatches;
	int  idle_cycles;
	int  send_gap;
	int  ready_stall;
	int  phase_cnt;
	bit  calm;
	bit  req_acc;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic queue_cmd(logic [2:0] op, logic [ID_W-1:0] a, logic [ID_W-1:0] b,
			bit drain = 1'b0);
		cmd_item_t item;
		item.beat.cmd    = op;
		item.beat.node_a = a;
		item.beat.node_b = b;
		item.drain       = drain;
		cmd_queue = {cmd_queue, item};
	endtask

	task automatic predict_command(input req_beat_t beat);
		rsp_beat_t       r;
		logic [NODE_COUNT-1:0] row;
		int              a;
		int              b;
		bit              listed;
		a = int'(beat.node_a);
		b = int'(beat.node_b);
		r = '0;
		r.last = 1'b1;
		case (beat.cmd)
			CMD_ADD_EDGE: begin
				if (a == b) begin
					r.error = 1'b1;
				end else if (!graph_links[a][b]) begin
					graph_links[a][b] = 1'b1;
					graph_links[b][a] = 1'b1;
					dirty_flag = 1'b1;
					r.answer = 1'b1;
				end
			end
			CMD_REM_EDGE: begin
				if (a == b) begin
					r.error = 1'b1;
				end else if (graph_links[a][b]) begin
					graph_links[a][b] = 1'b0;
					graph_links[b][a] = 1'b0;
					dirty_flag = 1'b1;
					r.answer = 1'b1;
				end
			end
			CMD_REM_NODE: begin
				if (graph_links[a] != '0) begin
					graph_links[a] = '0;
					for (int i = 0; i < NODE_COUNT; i++)
						graph_links[i][a] = 1'b0;
					dirty_flag = 1'b1;
					r.answer = 1'b1;
				end
			end
			CMD_HAS_EDGE: r.answer = graph_links[a][b];
			CMD_HAS_NODE: r.answer = |graph_links[a];
			CMD_LIST, CMD_LIST_ABOVE: begin
				row = graph_links[a];
				if (beat.cmd == CMD_LIST_ABOVE)
					row &= (a >= NODE_COUNT - 1) ? '0 : ({NODE_COUNT{1'b1}} << (a + 1));
				listed = 1'b0;
				for (int i = 0; i < NODE_COUNT; i++) begin
					if (row[i]) begin
						row[i] = 1'b0;
						r = '0;
						r.neighbour       = i[ID_W-1:0];
						r.neighbour_valid = 1'b1;
						r.last            = (row == '0);
						r.modified        = dirty_flag;
						due_beats = {due_beats, r};
						listed = 1'b1;
					end
				end
				if (listed)
					return;
			end
			default: begin
				r.answer = dirty_flag;
				dirty_flag = 1'b0;
			end
		endcase
		r.modified = dirty_flag;
		due_beats = {due_beats, r};
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		rsp_beat_t want;
		rsp_beat_t got;
		bit        moved;
		moved = 1'b0;
		req_acc <= req_if.valid && req_if.ready;
		if (arst_n && req_if.valid && req_if.ready) begin
			predict_command(req_if.data);
			moved = 1'b1;
		end
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			moved = 1'b1;
			got = rsp_if.data;
			if (due_beats.size() == 0) begin
				$display("%0t: no beat expected, got %p", $time, got);
				mismatches++;
			end else begin
				want = due_beats.pop_front();
				check_field("error", 8'(want.error), 8'(got.error));
				check_field("answer", 8'(want.answer), 8'(got.answer));
				check_field("neighbour", 8'(want.neighbour), 8'(got.neighbour));
				check_field("neighbour_valid", 8'(want.neighbour_valid),
					8'(got.neighbour_valid));
				check_field("last", 8'(want.last), 8'(got.last));
				check_field("modified", 8'(want.modified), 8'(got.modified));
			end
		end
		if (moved)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(negedge clk) begin
		cmd_item_t item;
		if (arst_n && !(req_if.valid && !req_acc)) begin
			if (send_gap > 0) begin
				req_if.valid <= 1'b0;
				send_gap--;
			end else if (cmd_queue.size() != 0
					&& !(cmd_queue[0].drain && due_beats.size() != 0)) begin
				item = cmd_queue.pop_front();
				req_if.data  <= item.beat;
				req_if.valid <= 1'b1;
				send_gap = calm ? 0 : pick_gap();
			end else begin
				req_if.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		phase_cnt++;
		if (phase_cnt % 200 == 0)
			calm <= ($urandom_range(0, 3) == 0);
		if (arst_n) begin
			if (ready_stall > 0) begin
				rsp_if.ready <= 1'b0;
				ready_stall--;
			end else begin
				rsp_if.ready <= 1'b1;
				ready_stall = calm ? 0 : pick_gap();
			end
		end
	end

	initial begin
		logic [ID_W-1:0] pool [8];
		logic [ID_W-1:0] a;
		logic [ID_W-1:0] b;
		logic [2:0]      op;
		int              left;
		int              episode;
		int              r;
		bit              star_done;

		arst_n       = 1'b0;
		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		req_acc      = 1'b0;
		calm         = 1'b0;
		dirty_flag   = 1'b0;
		for (int i = 0; i < NODE_COUNT; i++)
			graph_links[i] = '0;

		queue_cmd(CMD_READ_CLEAR, 6'd0, 6'd0);
		queue_cmd(CMD_HAS_NODE, 6'd0, 6'd0);
		queue_cmd(CMD_LIST, 6'd0, 6'd0);
		queue_cmd(CMD_ADD_EDGE, 6'd0, 6'd63);
		queue_cmd(CMD_ADD_EDGE, 6'd63, 6'd0);
		queue_cmd(CMD_ADD_EDGE, 6'd5, 6'd5);
		queue_cmd(CMD_REM_EDGE, 6'd7, 6'd7);
		queue_cmd(CMD_HAS_EDGE, 6'd63, 6'd0);
		queue_cmd(CMD_HAS_EDGE, 6'd3, 6'd3);
		queue_cmd(CMD_HAS_NODE, 6'd63, 6'd42);
		queue_cmd(CMD_LIST, 6'd0, 6'd0);
		queue_cmd(CMD_LIST_ABOVE, 6'd63, 6'd0);
		queue_cmd(CMD_ADD_EDGE, 6'd0, 6'd1);
		queue_cmd(CMD_ADD_EDGE, 6'd2, 6'd0);
		queue_cmd(CMD_LIST_ABOVE, 6'd0, 6'd0);
		queue_cmd(CMD_LIST_ABOVE, 6'd1, 6'd0);
		queue_cmd(CMD_READ_CLEAR, 6'd0, 6'd0);
		queue_cmd(CMD_READ_CLEAR, 6'd0, 6'd0);
		queue_cmd(CMD_REM_EDGE, 6'd0, 6'd1);
		queue_cmd(CMD_REM_EDGE, 6'd1, 6'd0);
		queue_cmd(CMD_REM_NODE, 6'd0, 6'd0);
		queue_cmd(CMD_REM_NODE, 6'd0, 6'd0);
		queue_cmd(CMD_HAS_NODE, 6'd63, 6'd0);
		queue_cmd(CMD_LIST, 6'd63, 6'd0);

		left = RANDOM_ITEMS;
		episode = 0;
		star_done = 1'b0;
		while (left > 0) begin
			if (episode == 0) begin
				episode = $urandom_range(20, 40);
				foreach (pool[i])
					pool[i] = ID_W'($urandom_range(0, NODE_COUNT - 1));
				if ($urandom_range(0, 1))
					pool[0] = 6'd0;
				if ($urandom_range(0, 1))
					pool[1] = 6'd63;
				queue_cmd(CMD_READ_CLEAR, ID_W'($urandom), ID_W'($urandom), 1'b1);
				left--;
			end
			if (!star_done && left < RANDOM_ITEMS / 2) begin
				star_done = 1'b1;
				a = ID_W'($urandom_range(0, NODE_COUNT - 1));
				for (int j = 0; j < NODE_COUNT; j++)
					if (j != int'(a))
						queue_cmd(CMD_ADD_EDGE, a, j[ID_W-1:0]);
				queue_cmd(CMD_LIST, a, ID_W'($urandom));
				queue_cmd(CMD_LIST_ABOVE, a, ID_W'($urandom));
				queue_cmd(CMD_LIST, ID_W'($urandom_range(0, NODE_COUNT - 1)), ID_W'($urandom));
				queue_cmd(CMD_REM_NODE, a, ID_W'($urandom), 1'b1);
				queue_cmd(CMD_LIST, a, ID_W'($urandom));
				left -= NODE_COUNT + 4;
			end
			r = $urandom_range(0, 99);
			if (r < 30)
				op = CMD_ADD_EDGE;
			else if (r < 40)
				op = CMD_REM_EDGE;
			else if (r < 46)
				op = CMD_REM_NODE;
			else if (r < 58)
				op = CMD_HAS_EDGE;
			else if (r < 66)
				op = CMD_HAS_NODE;
			else if (r < 78)
				op = CMD_LIST;
			else if (r < 90)
				op = CMD_LIST_ABOVE;
			else if (r < 96)
				op = CMD_READ_CLEAR;
			else
				op = 3'($urandom_range(0, 7));
			a = ($urandom_range(0, 99) < 85) ? pool[3'($urandom_range(0, 7))]
				: ID_W'($urandom);
			b = ($urandom_range(0, 99) < 85) ? pool[3'($urandom_range(0, 7))]
				: ID_W'($urandom);
			queue_cmd(op, a, b);
			left--;
			episode--;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_queue.size() != 0 || req_if.valid || due_beats.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && due_beats.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
